### hdl/prefix_code_tree_decoder_core_macros.svh
// assertion macros for the prefix code tree decoder
// used by the top level; no other dependencies
`ifndef PREFIX_CODE_TREE_DECODER_CORE_MACROS_SVH
`define PREFIX_CODE_TREE_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PTD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptd assertion failed");
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptd assertion failed");
`else
`define PTD_ASSERT_SAME(label, clk, rst, ante, cons)
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/ptd_pkg.sv
// shared types, codes and sizes for the prefix code tree decoder
// no dependencies
`timescale 1ns / 1ps

package ptd_pkg;

   localparam int NODES        = 512;
   localparam int MAX_CODE_LEN = 16;

   localparam int IDX_W  = $clog2(NODES);
   localparam int FREE_W = $clog2(NODES + 1);
   localparam int FUNC_W = 2;
   localparam int CODE_W = 16;
   localparam int LEN_W  = 5;
   localparam int SYM_W  = 8;
   localparam int STAT_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DECODE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_LEN = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
      logic [SYM_W-1:0] sym;
      logic             leaf;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   localparam node_type EMPTY_NODE = '{left: '0, right: '0, sym: '0, leaf: 1'b0};

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              bit_req;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
      logic [SYM_W-1:0]  symbol;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0]  out_symbol;
      logic              has_symbol;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      node_type         wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

endpackage

### hdl/prefix_code_tree_decoder_core.sv
// channel  | dir | handshake             | payload
// req      | in  | req_tvalid/req_tready | tuser func, tdata bit/code/length/symbol
// rsp      | out | rsp_tvalid/rsp_tready | tdata out_symbol, tuser has_symbol/status
//
// decode: finishes in the accepting state on a missing branch, else after one node ram read.
// insert: accept, then a step per newly allocated level, a step and a ram read per existing
// level, then a step to mark the leaf. clear and bad length finish in the accepting state.
// one request at a time; the result register holds until taken and a new
// request is taken as the result drains. synchronous reset empties the root
// register at once, no clearing pass. ram entries are written before read.
// depends on ptd_pkg, ptd_ctrl, ptd_ram and the macro header
`timescale 1ns / 1ps
`include "prefix_code_tree_decoder_core_macros.svh"

module prefix_code_tree_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // bit_req, code_bits[15:0], code_length[4:0], symbol[7:0]
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_symbol
   output logic [2:0]  rsp_tuser   // has_symbol, status[1:0]
);

   import ptd_pkg::*;

   req_type     req;
   rsp_type     result;
   mem_req_type mem_req;
   node_type    mem_rdata;
   logic [NODE_W-1:0] rdata_raw;
   logic        ctrl_idle;
   logic        ctrl_done;
   logic        start;

   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   assign req.func        = req_tuser;
   assign req.bit_req     = req_tdata[0];
   assign req.code_bits   = req_tdata[16:1];
   assign req.code_length = req_tdata[21:17];
   assign req.symbol      = req_tdata[29:22];

   assign req_tready = ctrl_idle && (!rsp_valid_ff || rsp_tready);
   assign start      = req_tvalid && req_tready;

   ptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .idle      (ctrl_idle),
      .done      (ctrl_done),
      .result    (result),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   ptd_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (rdata_raw)
   );

   assign mem_rdata = node_type'(rdata_raw);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctrl_done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.out_symbol;
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.has_symbol};

   // a finished request never lands on an untaken result
   `PTD_ASSERT_SAME(a_no_overrun, clock, reset, ctrl_done, !rsp_valid_ff || rsp_tready)
   // a symbol only comes with ok status
   `PTD_ASSERT_SAME(a_sym_ok, clock, reset, rsp_valid_ff && rsp_ff.has_symbol,
                    rsp_ff.status == STAT_OK)
   // no symbol means a zero symbol field
   `PTD_ASSERT_SAME(a_sym_zero, clock, reset, rsp_valid_ff && !rsp_ff.has_symbol,
                    rsp_ff.out_symbol == '0)
   // a started request leaves the walker busy or finished at once
   `PTD_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !ctrl_done,
                    !ctrl_idle || $past(ctrl_done) || rsp_valid_ff)

endmodule

### hdl/ptd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ptd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/ptd_ctrl.sv
// tree walker: insert, decode and clear sequencing over the node ram
// depends on ptd_pkg; the root node lives in a register, nodes 1 and up in ram
`timescale 1ns / 1ps

module ptd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ptd_pkg::req_type     req,
   output logic                 idle,
   output logic                 done,
   output ptd_pkg::rsp_type     result,
   output ptd_pkg::mem_req_type mem_req,
   input  ptd_pkg::node_type    mem_rdata
);

   import ptd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEC_WAIT,
      S_INS_STEP,
      S_INS_WAIT
   } state_type;

   state_type         state_ff,     state_in;
   node_type          root_ff,      root_in;
   node_type          cur_ff,       cur_in;
   logic              at_root_ff,   at_root_in;
   logic [FREE_W-1:0] next_free_ff, next_free_in;
   node_type          ins_rec_ff,   ins_rec_in;
   logic [IDX_W-1:0]  ins_idx_ff,   ins_idx_in;
   logic [LEN_W-1:0]  ins_cnt_ff,   ins_cnt_in;
   logic [CODE_W-1:0] code_ff,      code_in;
   logic [SYM_W-1:0]  sym_ff,       sym_in;

   node_type         here;
   node_type         wr_rec;
   logic             wr_en;
   logic [IDX_W-1:0] child;
   logic             step_bit;
   logic [LEN_W-1:0] pos;

   function automatic logic code_bit(input logic [CODE_W-1:0] c, input logic [LEN_W-1:0] p);
      logic r;
      r = 1'b0;
      if (p < LEN_W'(CODE_W)) begin
         r = c[p[$clog2(CODE_W)-1:0]];
      end
      return r;
   endfunction

   assign idle = (state_ff == S_IDLE);
   assign here = at_root_ff ? root_ff : cur_ff;
   assign pos  = ins_cnt_ff - LEN_W'(1);

   always_comb begin
      state_in     = state_ff;
      root_in      = root_ff;
      cur_in       = cur_ff;
      at_root_in   = at_root_ff;
      next_free_in = next_free_ff;
      ins_rec_in   = ins_rec_ff;
      ins_idx_in   = ins_idx_ff;
      ins_cnt_in   = ins_cnt_ff;
      code_in      = code_ff;
      sym_in       = sym_ff;
      done         = 1'b0;
      result       = '{out_symbol: '0, has_symbol: 1'b0, status: STAT_OK};
      wr_en        = 1'b0;
      wr_rec       = ins_rec_ff;
      step_bit     = 1'b0;
      child        = '0;
      mem_req      = '{we: 1'b0, waddr: ins_idx_ff, wdata: ins_rec_ff, raddr: '0};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req.func)
                  FUNC_INSERT: begin
                     at_root_in = 1'b1;
                     if (req.code_length == '0 ||
                         req.code_length > LEN_W'(MAX_CODE_LEN)) begin
                        done          = 1'b1;
                        result.status = STAT_BAD_LEN;
                     end else begin
                        ins_rec_in = root_ff;
                        ins_idx_in = '0;
                        ins_cnt_in = req.code_length;
                        code_in    = req.code_bits;
                        sym_in     = req.symbol;
                        state_in   = S_INS_STEP;
                     end
                  end
                  FUNC_DECODE: begin
                     child = req.bit_req ? here.right : here.left;
                     if (child == '0) begin
                        done          = 1'b1;
                        result.status = STAT_MISSING;
                        at_root_in    = 1'b1;
                     end else begin
                        mem_req.raddr = child;
                        state_in      = S_DEC_WAIT;
                     end
                  end
                  FUNC_CLEAR: begin
                     done         = 1'b1;
                     root_in      = EMPTY_NODE;
                     next_free_in = FREE_W'(1);
                     at_root_in   = 1'b1;
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         S_DEC_WAIT: begin
            done = 1'b1;
            if (mem_rdata.leaf) begin
               result.has_symbol = 1'b1;
               result.out_symbol = mem_rdata.sym;
               at_root_in        = 1'b1;
            end else begin
               cur_in     = mem_rdata;
               at_root_in = 1'b0;
            end
            state_in = S_IDLE;
         end

         S_INS_STEP: begin
            if (ins_cnt_ff == '0) begin
               wr_rec      = ins_rec_ff;
               wr_rec.leaf = 1'b1;
               wr_rec.sym  = sym_ff;
               wr_en       = 1'b1;
               done        = 1'b1;
               state_in    = S_IDLE;
            end else begin
               step_bit = code_bit(code_ff, pos);
               child    = step_bit ? ins_rec_ff.right : ins_rec_ff.left;
               if (child == '0) begin
                  if (next_free_ff >= FREE_W'(NODES)) begin
                     // flush the node in hand, it may be freshly allocated
                     wr_en         = 1'b1;
                     done          = 1'b1;
                     result.status = STAT_FULL;
                     state_in      = S_IDLE;
                  end else begin
                     wr_en       = 1'b1;
                     wr_rec.leaf = 1'b0;
                     if (step_bit) begin
                        wr_rec.right = next_free_ff[IDX_W-1:0];
                     end else begin
                        wr_rec.left  = next_free_ff[IDX_W-1:0];
                     end
                     ins_rec_in   = EMPTY_NODE;
                     ins_idx_in   = next_free_ff[IDX_W-1:0];
                     next_free_in = next_free_ff + FREE_W'(1);
                     ins_cnt_in   = pos;
                  end
               end else begin
                  mem_req.raddr = child;
                  ins_idx_in    = child;
                  ins_cnt_in    = pos;
                  state_in      = S_INS_WAIT;
               end
            end
         end

         S_INS_WAIT: begin
            ins_rec_in = mem_rdata;
            state_in   = S_INS_STEP;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // node zero is the root register, the rest go to ram
      if (wr_en) begin
         if (ins_idx_ff == '0) begin
            root_in = wr_rec;
         end else begin
            mem_req.we    = 1'b1;
            mem_req.wdata = wr_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         root_ff      <= EMPTY_NODE;
         at_root_ff   <= 1'b1;
         next_free_ff <= FREE_W'(1);
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         at_root_ff   <= at_root_in;
         next_free_ff <= next_free_in;
      end
      cur_ff     <= cur_in;
      ins_rec_ff <= ins_rec_in;
      ins_idx_ff <= ins_idx_in;
      ins_cnt_ff <= ins_cnt_in;
      code_ff    <= code_in;
      sym_ff     <= sym_in;
   end

endmodule
